### src/lzsd_pkg.sv
package lzsd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int LOOKAHEAD = 16;
    localparam int MIN_MATCH_EXTRA = 2;
    localparam int ADDR_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = ADDR_W + 1;

    localparam logic [ADDR_W-1:0] WP_START = ADDR_W'(WINDOW_SIZE - LOOKAHEAD);
    localparam logic [7:0] FILL_RESET = 8'd32;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // command kinds passed from the front to the back
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LIT = 2'd1;
    localparam logic [1:0] CMD_MATCH = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] arg;
        logic [3:0]        nib;
    } t_cmd;

endpackage

### src/lzsd_in_if.sv
interface lzsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_start;

    modport source (output valid, output in_byte, output stream_start, input ready);
    modport sink (input valid, input in_byte, input stream_start, output ready);
endinterface

### src/lzsd_out_if.sv
interface lzsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

### src/lzsd_front.sv
module lzsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lzsd_in_if.sink       i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output lzsd_pkg::t_cmd o_cmd
);
    import lzsd_pkg::*;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LIT = 2'd1;
    localparam logic [1:0] PH_LOW = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    logic [8:0] r_flags, n_flags;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_low, n_low;

    logic       accept;
    logic [8:0] cur_flags;
    logic [1:0] cur_phase;
    logic [7:0] cur_low;
    logic [7:0] b;

    function automatic logic [1:0] pick_phase(input logic [8:0] f);
        if (f <= 9'd1) begin
            return PH_FLAG;
        end else if (f[0]) begin
            return PH_LIT;
        end else begin
            return PH_LOW;
        end
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept = i_in.valid && !i_q_full;
    assign b = i_in.in_byte;

    always_comb begin
        cur_flags = i_in.stream_start ? 9'd0 : r_flags;
        cur_phase = i_in.stream_start ? PH_FLAG : r_phase;
        cur_low = i_in.stream_start ? 8'd0 : r_low;

        n_flags = r_flags;
        n_phase = r_phase;
        n_low = r_low;
        o_push = 1'b0;
        o_cmd = '0;

        if (accept) begin
            n_flags = cur_flags;
            n_phase = cur_phase;
            n_low = cur_low;
            case (cur_phase)
                PH_FLAG: begin
                    n_flags = {1'b1, b};
                    n_phase = pick_phase({1'b1, b});
                    // a start marker only reaches the back as a reinit word
                    if (i_in.stream_start) begin
                        o_push = 1'b1;
                        o_cmd.kind = CMD_START;
                    end
                end
                PH_LIT: begin
                    o_push = 1'b1;
                    o_cmd.kind = CMD_LIT;
                    o_cmd.arg = ADDR_W'(b);
                    n_flags = cur_flags >> 1;
                    n_phase = pick_phase(cur_flags >> 1);
                end
                PH_LOW: begin
                    n_low = b;
                    n_phase = PH_HIGH;
                end
                PH_HIGH: begin
                    o_push = 1'b1;
                    o_cmd.kind = CMD_MATCH;
                    o_cmd.arg = {b[7:4], cur_low};
                    o_cmd.nib = b[3:0];
                    n_flags = cur_flags >> 1;
                    n_phase = pick_phase(cur_flags >> 1);
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 9'd0;
            r_phase <= PH_FLAG;
            r_low <= 8'd0;
        end else begin
            r_flags <= n_flags;
            r_phase <= n_phase;
            r_low <= n_low;
        end
    end

endmodule

### src/lzsd_cmd_fifo.sv
module lzsd_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lzsd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lzsd_pkg::t_cmd o_cmd
);
    import lzsd_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr, n_wr;
    logic [CMD_PTR_W-1:0] r_rd, n_rd;
    logic [CMD_PTR_W:0]   r_cnt, n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full = (r_cnt == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_comb begin
        n_wr = do_push ? r_wr + 1'b1 : r_wr;
        n_rd = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

### src/lzsd_back.sv
module lzsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_fill_byte,
    input  logic           i_empty,
    input  lzsd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    lzsd_out_if.source     o_out
);
    import lzsd_pkg::*;

    logic [7:0] r_win [WINDOW_SIZE];
    logic [7:0] r_mem_q;

    logic              r_busy, n_busy;
    logic [1:0]        r_kind, n_kind;
    logic [ADDR_W-1:0] r_arg, n_arg;
    logic [3:0]        r_nib, n_nib;
    logic [4:0]        r_k, n_k;

    logic [ADDR_W-1:0] r_wp, n_wp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_start_fill, n_start_fill;

    logic       r_s1_valid, n_s1_valid;
    logic       r_s1_fwd, n_s1_fwd;
    logic [7:0] r_s1_data, n_s1_data;
    logic       r_s1_last, n_s1_last;

    logic       r_o_valid, n_o_valid;
    logic [7:0] r_o_byte, n_o_byte;
    logic       r_o_last, n_o_last;

    logic [7:0]        s1_byte;
    logic              s1_move;
    logic              s1_free;
    logic              issue;
    logic              match_last;
    logic              issue_done;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic              fwd_hit;
    logic              written;
    logic [7:0]        dflt;
    logic              can_pop;
    logic              start_pop;

    assign s1_byte = r_s1_fwd ? r_s1_data : r_mem_q;
    assign s1_move = r_s1_valid && (!r_o_valid || o_out.ready);
    assign s1_free = !r_s1_valid || s1_move;
    assign issue = r_busy && s1_free;
    assign match_last = (r_k == ({1'b0, r_nib} + 5'(MIN_MATCH_EXTRA)));
    assign issue_done = issue && ((r_kind == CMD_LIT) || match_last);
    assign rd_addr = r_arg + ADDR_W'(r_k);
    assign rd_en = issue && (r_kind == CMD_MATCH);
    // copy at distance one reads the byte being written in the same cycle
    assign fwd_hit = s1_move && (rd_addr == r_wp);
    // entries are written in order from the start pointer, so a count tells which hold data
    assign written = ({1'b0, rd_addr - WP_START} < r_count);
    assign dflt = (rd_addr < WP_START) ? r_start_fill : 8'h00;
    assign can_pop = !i_empty && ((i_cmd.kind == CMD_START) ? (!r_busy && !r_s1_valid)
                                                              : (!r_busy || issue_done));
    assign start_pop = can_pop && (i_cmd.kind == CMD_START);
    assign o_pop = can_pop;

    assign o_out.valid = r_o_valid;
    assign o_out.out_byte = r_o_byte;
    assign o_out.run_last = r_o_last;

    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        n_arg = r_arg;
        n_nib = r_nib;
        n_k = r_k;
        n_wp = r_wp;
        n_count = r_count;
        n_start_fill = r_start_fill;
        n_s1_valid = r_s1_valid;
        n_s1_fwd = r_s1_fwd;
        n_s1_data = r_s1_data;
        n_s1_last = r_s1_last;
        n_o_valid = r_o_valid;
        n_o_byte = r_o_byte;
        n_o_last = r_o_last;

        if (issue) begin
            n_s1_valid = 1'b1;
            if (r_kind == CMD_LIT) begin
                n_s1_fwd = 1'b1;
                n_s1_data = r_arg[7:0];
                n_s1_last = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_s1_fwd = fwd_hit || !written;
                n_s1_data = fwd_hit ? s1_byte : dflt;
                n_s1_last = match_last;
                n_k = r_k + 5'd1;
                if (match_last) begin
                    n_busy = 1'b0;
                end
            end
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end

        if (s1_move) begin
            n_o_valid = 1'b1;
            n_o_byte = s1_byte;
            n_o_last = r_s1_last;
            n_wp = r_wp + 1'b1;
            if (r_count != CNT_W'(WINDOW_SIZE)) begin
                n_count = r_count + 1'b1;
            end
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end

        if (can_pop) begin
            if (i_cmd.kind == CMD_START) begin
                n_wp = WP_START;
                n_count = '0;
                n_start_fill = i_fill_byte;
            end else begin
                n_busy = 1'b1;
                n_kind = i_cmd.kind;
                n_arg = i_cmd.arg;
                n_nib = i_cmd.nib;
                n_k = 5'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_win[r_wp] <= s1_byte;
        end
        if (rd_en) begin
            r_mem_q <= r_win[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_arg <= n_arg;
        r_nib <= n_nib;
        r_k <= n_k;
        r_s1_fwd <= n_s1_fwd;
        r_s1_data <= n_s1_data;
        r_s1_last <= n_s1_last;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_wp <= WP_START;
            r_count <= '0;
            r_start_fill <= FILL_RESET;
        end else begin
            r_busy <= n_busy;
            r_s1_valid <= n_s1_valid;
            r_o_valid <= n_o_valid;
            r_wp <= n_wp;
            r_count <= n_count;
            r_start_fill <= n_start_fill;
        end
    end

    // once the whole window holds data the count stops and the pointer runs on
    a_wp_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(WINDOW_SIZE)) || (r_wp == WP_START + r_count[ADDR_W-1:0]))
        else $error("write pointer out of step with fill count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_SIZE))
        else $error("fill count beyond window size");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_pop |=> (r_count == '0) && !r_s1_valid && !r_busy)
        else $error("reinit taken while a copy was in flight");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> r_s1_valid && $stable(r_s1_data) && $stable(r_s1_fwd))
        else $error("stalled copy stage lost its byte");

endmodule

### src/lzss_window_decoder.sv
// LZSS (SZDD-style) decoder with a 4096-byte window. Each input word is one
// compressed byte; stream_start reinitializes the window (fill_byte below 4080,
// zero above), the write pointer (4080) and the flag state before that byte is
// used. The front classifies bytes at one per cycle while the queue is not full
// and posts literal, match and reinit commands into a four-entry queue. The back
// emits one byte per cycle while the output is ready, limited by the single read
// port of the window memory: a literal gives one byte and a match gives L bytes
// (3 to 18), and the next command is taken in the cycle of the last byte. A
// stream start waits for the copy stage to drain. Flag bytes and match low bytes
// produce nothing. A fill count stands in for clearing the window, so there is
// no clearing pass after reset or at stream start. fill_byte takes effect at the
// next stream start; reset restores the default fill byte (32).
module lzss_window_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    lzsd_in_if.sink    i_in,
    lzsd_out_if.source o_out
);
    import lzsd_pkg::*;

    logic [7:0] r_fill_byte;

    logic q_push;
    t_cmd q_in_cmd;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_out_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_byte <= FILL_RESET;
        end else if (i_cfg_we) begin
            r_fill_byte <= i_cfg_data;
        end
    end

    lzsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (q_in_cmd)
    );

    lzsd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd)
    );

    lzsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fill_byte (r_fill_byte),
        .i_empty     (q_empty),
        .i_cmd       (q_out_cmd),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule
